>>> hdl/lacd_pkg.sv
// Shared types, sizes and helpers of the LRU cache directory.
// Used by the RAM-based top level and by its port checker.
package lacd_pkg;

  // number of directory lines
  localparam int LINES = 16;

  // line index and scan counter widths
  localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int CNT_W = $clog2(LINES + 1);

  // field widths
  localparam int KEY_W   = 64;
  localparam int LEN_W   = 20;
  localparam int AGE_W   = 32;
  localparam int LINE_W  = 8;
  localparam int STAT_W  = 2;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;
  localparam int S_TDATA_W = ((KEY_W + LEN_W + 7) / 8) * 8;

  // config register
  localparam logic [LEN_W-1:0] MAX_OBJ_RESET = LEN_W'(102400);
  localparam logic REG_MAX_OBJ = 1'b0;

  // operation codes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_MISS   = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  typedef logic signed [AGE_W-1:0] age_t;

  // ages written after the common decrement
  localparam age_t AGE_MIN  = {1'b1, {(AGE_W-1){1'b0}}};
  localparam age_t AGE_HIT  = AGE_W'(LINES - 1);
  localparam age_t AGE_FILL = AGE_W'(LINES);

  // saturating decrement
  function automatic age_t age_dec(input age_t a);
    age_t r;
    if (a == AGE_MIN) begin
      r = a;
    end else begin
      r = a - age_t'(1);
    end
    return r;
  endfunction

endpackage

>>> hdl/lru_assoc_cache_directory.sv
// Directory of a fully associative cache with counter-based LRU replacement.
// Depends on lacd_pkg and on lacd_ram for the key and age stores.
//
// Requests arrive on the s_axis channel (tuser = operation, tdata = key and
// object length); one result per request leaves on m_axis (tuser = status,
// tdata = line index). One request is in work at a time; s_axis_tready is
// high while the directory waits for the next request.
// Every request but a rejected insert walks the key and age RAMs one line
// per cycle through their single read port. A lookup hit needs a second
// pass for the common age decrement once the hit is known.
// Inserts decrement ages during the scan itself and write the chosen line
// afterwards. The result sits in an output register; a new request is taken
// while it waits, and the next result waits until m_axis_tready drains it.
// Reset clears all valid bits, the output and max_object_bytes (to 102400);
// key and age RAMs need no clearing since only the contents of valid lines are used.
// max_object_bytes is written over APB at address 0, read back likewise.
module lru_assoc_cache_directory
  import lacd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request channel
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // key [63:0], object_length [83:64], zero pad
  input  logic                  s_axis_tuser,   // operation [0]
  // result channel
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [LINE_W-1:0]     m_axis_tdata,   // line_index [7:0]
  output logic [STAT_W-1:0]     m_axis_tuser,   // status [1:0]
  // config port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_AGE,
    S_RESP
  } state_e;

  state_e             state_q;
  logic [LINES-1:0]   valid_q;
  logic [LEN_W-1:0]   max_len_q;
  logic [CNT_W-1:0]   rd_cnt_q;
  logic               chk_vld_q;
  logic [IDX_W-1:0]   chk_idx_q;
  logic               found_q;
  logic               free_q;
  logic               m_valid_q;

  logic               op_q;
  logic [KEY_W-1:0]   key_q;
  logic [IDX_W-1:0]   match_idx_q;
  logic [IDX_W-1:0]   free_idx_q;
  logic [IDX_W-1:0]   min_idx_q;
  age_t               min_age_q;
  status_e            res_status_q;
  logic [IDX_W-1:0]   res_idx_q;
  status_e            m_status_q;
  logic [LINE_W-1:0]  m_index_q;

  logic               s_accept;
  logic               cfg_write;
  logic [LEN_W-1:0]   req_len;
  logic               req_op;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               scan_last;
  logic               key_hit;
  logic               is_free;
  logic               min_take;
  logic [IDX_W-1:0]   ins_idx;
  logic               out_load;

  logic [KEY_W-1:0]   key_rdata;
  logic [AGE_W-1:0]   age_rdata;
  age_t               age_rd;
  logic               key_we;
  logic               age_we;
  logic [IDX_W-1:0]   age_waddr;
  age_t               age_wdata;

  // handshakes and request fields
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign req_op        = s_axis_tuser;
  assign req_len       = s_axis_tdata[KEY_W +: LEN_W];
  assign cfg_write     = psel && penable && pwrite && pready;
  assign pready        = 1'b1;
  assign prdata        = (paddr[2] == REG_MAX_OBJ) ? DATA_W'(max_len_q) : '0;

  // line walk: read issue and compare stage
  assign rd_en     = ((state_q == S_SCAN) || (state_q == S_AGE)) &&
                     (rd_cnt_q < CNT_W'(LINES));
  assign rd_addr   = rd_cnt_q[IDX_W-1:0];
  assign scan_last = chk_vld_q && (chk_idx_q == IDX_W'(LINES - 1));
  assign age_rd    = $signed(age_rdata);
  assign key_hit   = valid_q[chk_idx_q] && (key_rdata == key_q);
  assign is_free   = !valid_q[chk_idx_q];
  assign min_take  = (chk_idx_q == '0) || (age_rd < min_age_q);
  assign ins_idx   = free_q ? free_idx_q : min_idx_q;
  assign out_load  = (state_q == S_RESP) && (!m_valid_q || m_axis_tready);

  // write port selection of the key and age stores
  always_comb begin
    key_we    = (state_q == S_DECIDE) && (op_q == OP_INSERT);
    age_we    = 1'b0;
    age_waddr = chk_idx_q;
    age_wdata = age_dec(age_rd);
    unique case (state_q)
      S_SCAN: begin
        age_we = chk_vld_q && (op_q == OP_INSERT);
      end
      S_AGE: begin
        age_we = chk_vld_q;
        if (chk_idx_q == match_idx_q) begin
          age_wdata = AGE_HIT;
        end
      end
      S_DECIDE: begin
        if (op_q == OP_INSERT) begin
          age_we    = 1'b1;
          age_waddr = ins_idx;
          age_wdata = AGE_FILL;
        end
      end
      default: begin
      end
    endcase
  end

  lacd_ram #(
    .Width (KEY_W),
    .Depth (LINES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (ins_idx),
    .wdata_i (key_q),
    .raddr_i (rd_addr),
    .rdata_o (key_rdata)
  );

  lacd_ram #(
    .Width (AGE_W),
    .Depth (LINES)
  ) u_age_ram (
    .clk_i   (clk_i),
    .we_i    (age_we),
    .waddr_i (age_waddr),
    .wdata_i (age_wdata),
    .raddr_i (rd_addr),
    .rdata_o (age_rdata)
  );

  // control state machine and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      valid_q   <= '0;
      max_len_q <= MAX_OBJ_RESET;
      rd_cnt_q  <= '0;
      chk_vld_q <= 1'b0;
      found_q   <= 1'b0;
      free_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      chk_vld_q <= rd_en;
      // walk counter restarts for each scan and for the aging pass
      if (s_accept || (state_q == S_DECIDE)) begin
        rd_cnt_q <= '0;
      end else begin
        rd_cnt_q <= rd_cnt_q + CNT_W'(rd_en);
      end
      if (cfg_write && (paddr[2] == REG_MAX_OBJ)) begin
        max_len_q <= pwdata[LEN_W-1:0];
      end
      // output register: load a new result or drain the old one
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_accept) begin
            found_q  <= 1'b0;
            free_q   <= 1'b0;
            if ((req_op == OP_INSERT) && (req_len > max_len_q)) begin
              state_q <= S_RESP;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (chk_vld_q) begin
            if ((op_q == OP_LOOKUP) && key_hit) begin
              found_q <= 1'b1;
            end
            if ((op_q == OP_INSERT) && is_free) begin
              free_q <= 1'b1;
            end
          end
          if (scan_last) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (op_q == OP_INSERT) begin
            valid_q[ins_idx] <= 1'b1;
            state_q          <= S_RESP;
          end else if (found_q) begin
            state_q  <= S_AGE;
          end else begin
            state_q <= S_RESP;
          end
        end
        S_AGE: begin
          if (scan_last) begin
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_load) begin
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // request, search and result payload
  always_ff @(posedge clk_i) begin
    chk_idx_q <= rd_addr;
    if (s_accept) begin
      op_q         <= req_op;
      key_q        <= s_axis_tdata[KEY_W-1:0];
      res_status_q <= ST_REJECT;
      res_idx_q    <= '0;
    end
    if ((state_q == S_SCAN) && chk_vld_q) begin
      if (!found_q && key_hit) begin
        match_idx_q <= chk_idx_q;
      end
      if (!free_q && is_free) begin
        free_idx_q <= chk_idx_q;
      end
      if (min_take) begin
        min_age_q <= age_rd;
        min_idx_q <= chk_idx_q;
      end
    end
    if (state_q == S_DECIDE) begin
      if (op_q == OP_INSERT) begin
        res_status_q <= ST_OK;
        res_idx_q    <= ins_idx;
      end else if (found_q) begin
        res_status_q <= ST_OK;
        res_idx_q    <= match_idx_q;
      end else begin
        res_status_q <= ST_MISS;
        res_idx_q    <= '0;
      end
    end
    if (out_load) begin
      m_status_q <= res_status_q;
      m_index_q  <= LINE_W'(res_idx_q);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = m_index_q;

endmodule

>>> hdl/lacd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone, no package dependency.
module lacd_ram #(
  parameter int Width = 64,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AddrW-1:0]             waddr_i,
  input  logic [Width-1:0]             wdata_i,
  input  logic [AddrW-1:0]             raddr_i,
  output logic [Width-1:0]             rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> hdl/lacd_checker.sv
// Port-level checker of the LRU cache directory, bound to its top level.
// Depends on lacd_pkg for widths and status codes.
module lacd_checker
  import lacd_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [LINE_W-1:0]    m_axis_tdata,
  input logic [STAT_W-1:0]    m_axis_tuser,
  input logic                 pready
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // miss and reject carry line zero
  a_zero_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tdata == '0)
    else $error("line index nonzero on miss or reject");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == ST_OK) || (m_axis_tuser == ST_MISS) ||
                      (m_axis_tuser == ST_REJECT))
    else $error("undefined status code");

  // one request in work at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // config port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind lru_assoc_cache_directory lacd_checker u_lacd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .pready        (pready)
);
